>>> src/stream_duration_pair_checker_top_assert.svh
`ifndef STREAM_DURATION_PAIR_CHECKER_TOP_ASSERT_SVH
`define STREAM_DURATION_PAIR_CHECKER_TOP_ASSERT_SVH
// Assertion helpers shared by the checker.
`define SDPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SDPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> src/sdpc_pkg.sv
package sdpc_pkg;
    localparam int MaxStreams    = 8;
    localparam int RingDepth     = 16;
    localparam int NumFormatters = 2;
    localparam int NumRings      = MaxStreams * NumFormatters;
    localparam int StoreDepth    = NumRings * RingDepth;
    localparam int AddrW         = $clog2(StoreDepth);
    localparam int SlotW         = $clog2(RingDepth);
    localparam int RingW         = $clog2(NumRings);
    localparam int QueueDepth    = 2;

    localparam logic [2:0] RegRingLength  = 3'd0;
    localparam logic [2:0] RegStreamCount = 3'd1;
    localparam logic [2:0] RegActiveMask  = 3'd2;
    localparam logic [2:0] RegDeadMask    = 3'd3;
    localparam logic [2:0] RegTolerance   = 3'd4;

    localparam logic [1:0] StatusOk       = 2'd0;
    localparam logic [1:0] StatusMismatch = 2'd1;
    localparam logic [1:0] StatusUnknown  = 2'd2;

    typedef enum logic [1:0] {
        t_op_enter,
        t_op_check,
        t_op_direct
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [1:0]  status;
        logic [2:0]  stream_index;
        logic        fmt;
        logic [31:0] seq_num;
        logic [31:0] duration;
    } t_task;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  conflict_stream;
        logic [31:0] conflict_duration;
    } t_result;

    typedef struct packed {
        logic [4:0]  ring_length;
        logic [3:0]  stream_count;
        logic [7:0]  active_mask;
        logic [7:0]  dead_mask;
        logic [30:0] tolerance;
    } t_cfg;

    typedef enum logic [2:0] {
        t_st_idle,
        t_st_write,
        t_st_next_stream,
        t_st_read,
        t_st_eval,
        t_st_wipe,
        t_st_done
    } t_state;
endpackage

>>> src/sdpc_ram.sv
module sdpc_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/sdpc_front.sv
module sdpc_front import sdpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_cmd,
    input  logic [2:0]  i_stream_index,
    input  logic [1:0]  i_formatter,
    input  logic [31:0] i_seq_num,
    input  logic [31:0] i_duration,
    output logic        o_task_valid,
    output t_task       o_task,
    input  logic        i_task_take
);
    t_task r_q [QueueDepth];
    logic [$clog2(QueueDepth)-1:0] r_wr, r_rd;
    logic [$clog2(QueueDepth):0] r_cnt;
    logic  push_ok;
    t_task n_task;

    assign o_full       = (r_cnt == ($clog2(QueueDepth)+1)'(QueueDepth));
    assign push_ok      = i_push && !o_full;
    assign o_task_valid = (r_cnt != '0);
    assign o_task       = r_q[r_rd];

    always_comb begin
        n_task.stream_index = i_stream_index;
        n_task.fmt          = i_formatter[0];
        n_task.seq_num      = i_seq_num;
        n_task.duration     = i_duration;
        n_task.status       = StatusOk;
        if (i_formatter >= 2'(NumFormatters)) begin
            n_task.op = t_op_direct;
            if (!i_cmd) begin
                n_task.status = StatusUnknown;
            end
        end else if (i_cmd) begin
            n_task.op = t_op_check;
        end else begin
            n_task.op = t_op_enter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr] <= n_task;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_task_take) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + ($clog2(QueueDepth)+1)'(push_ok)
                           - ($clog2(QueueDepth)+1)'(i_task_take);
        end
    end
endmodule

>>> src/sdpc_back.sv
module sdpc_back import sdpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_task_valid,
    input  t_task       i_task,
    output logic        o_task_take,
    output logic        o_res_valid,
    output t_result     o_res,
    input  logic        i_res_take
);
    t_state r_state, n_state;
    logic [AddrW-1:0] r_wipe, n_wipe;
    logic [SlotW-1:0] r_wp [NumRings];
    logic [3:0] r_stream, n_stream;
    logic [3:0] r_limit, n_limit;
    logic [SlotW:0] r_slot, n_slot;
    t_result r_res, n_res;
    logic r_res_valid, n_res_valid;
    t_task r_task;
    logic n_task_load;

    logic we, wp_we;
    logic [AddrW-1:0] waddr, raddr;
    logic [31:0] wseq, wdur, rseq, rdur;
    logic [SlotW:0] len;
    logic [RingW-1:0] ring_w, ring_r;
    logic [SlotW-1:0] wp_cur;
    logic [SlotW:0] wp_inc;
    logic [31:0] diff, mag;
    logic in_tol;
    logic act, dead;

    sdpc_ram #(.Width(32), .Depth(StoreDepth)) u_seq (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wseq),
        .i_raddr(raddr), .o_rdata(rseq)
    );
    sdpc_ram #(.Width(32), .Depth(StoreDepth)) u_dur (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdur),
        .i_raddr(raddr), .o_rdata(rdur)
    );

    always_comb begin
        if (i_cfg.ring_length == '0) begin
            len = (SlotW+1)'(1);
        end else if (i_cfg.ring_length > 5'(RingDepth)) begin
            len = (SlotW+1)'(RingDepth);
        end else begin
            len = (SlotW+1)'(i_cfg.ring_length);
        end
    end

    assign ring_w = RingW'({r_task.stream_index, r_task.fmt});
    assign ring_r = RingW'({r_stream[2:0], r_task.fmt});
    assign wp_cur = r_wp[ring_w];
    assign wp_inc = (SlotW+1)'(wp_cur) + 1'b1;
    assign raddr  = AddrW'({ring_r, r_slot[SlotW-1:0]});
    assign diff   = rdur - r_task.duration;
    assign mag    = diff[31] ? (32'd0 - diff) : diff;
    assign in_tol = diff[31] ? (diff != 32'h8000_0000 && mag < {1'b0, i_cfg.tolerance})
                             : (mag < {1'b0, i_cfg.tolerance});
    assign act    = i_cfg.active_mask[r_stream[2:0]];
    assign dead   = i_cfg.dead_mask[r_stream[2:0]];
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_state     = r_state;
        n_wipe      = r_wipe;
        n_stream    = r_stream;
        n_limit     = r_limit;
        n_slot      = r_slot;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_res_take;
        n_task_load = 1'b0;
        o_task_take = 1'b0;
        we          = 1'b0;
        wp_we       = 1'b0;
        waddr       = AddrW'({ring_w, wp_cur});
        wseq        = r_task.seq_num;
        wdur        = r_task.duration;
        unique case (r_state)
            t_st_wipe: begin
                we    = 1'b1;
                waddr = r_wipe;
                wseq  = '1;
                wdur  = '1;
                n_wipe = r_wipe + 1'b1;
                if (r_wipe == AddrW'(StoreDepth - 1)) begin
                    n_state = t_st_idle;
                end
            end
            t_st_idle: begin
                if (i_task_valid && !n_res_valid) begin
                    o_task_take = 1'b1;
                    n_task_load = 1'b1;
                    n_res       = '0;
                    n_res.status = i_task.status;
                    unique case (i_task.op)
                        t_op_enter:  n_state = t_st_write;
                        t_op_check:  n_state = t_st_next_stream;
                        default:     n_state = t_st_done;
                    endcase
                    n_stream = '0;
                    n_limit  = (i_cfg.stream_count > 4'(MaxStreams)) ?
                               4'(MaxStreams) : i_cfg.stream_count;
                end
            end
            t_st_write: begin
                we    = 1'b1;
                wp_we = 1'b1;
                n_state = t_st_done;
            end
            t_st_next_stream: begin
                n_slot  = '0;
                if (r_stream >= r_limit) begin
                    n_state = t_st_done;
                end else if (act) begin
                    if (r_stream[2:0] == r_task.stream_index) begin
                        n_stream = r_stream + 1'b1;
                    end else begin
                        n_state = t_st_read;
                    end
                end else begin
                    if (dead && r_limit < 4'(MaxStreams)) begin
                        n_limit = r_limit + 1'b1;
                    end
                    n_stream = r_stream + 1'b1;
                end
            end
            t_st_read: begin
                n_state = t_st_eval;
            end
            t_st_eval: begin
                if (rseq == r_task.seq_num) begin
                    if (!in_tol && rdur != '1) begin
                        n_res.status            = StatusMismatch;
                        n_res.conflict_stream   = r_stream[2:0];
                        n_res.conflict_duration = rdur;
                        n_state = t_st_done;
                    end else begin
                        n_stream = r_stream + 1'b1;
                        n_state  = t_st_next_stream;
                    end
                end else if (r_slot + 1'b1 >= len) begin
                    n_stream = r_stream + 1'b1;
                    n_state  = t_st_next_stream;
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_state = t_st_read;
                end
            end
            t_st_done: begin
                n_res_valid = 1'b1;
                n_state     = t_st_idle;
            end
            default: n_state = t_st_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_stream <= n_stream;
        r_limit  <= n_limit;
        r_slot   <= n_slot;
        r_res    <= n_res;
        if (n_task_load) begin
            r_task <= i_task;
        end
        if (!i_rst_n) begin
            r_state     <= t_st_wipe;
            r_wipe      <= '0;
            r_res_valid <= 1'b0;
            for (int i = 0; i < NumRings; i++) begin
                r_wp[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_wipe      <= n_wipe;
            r_res_valid <= n_res_valid;
            if (wp_we) begin
                r_wp[ring_w] <= (wp_inc >= len) ? '0 : wp_inc[SlotW-1:0];
            end
        end
    end
endmodule

>>> src/stream_duration_pair_checker_top.sv
// Stream duration pair checker.
// Input channel: push/full with cmd, stream_index, formatter, seq_num, duration.
// Result channel: empty/pop with status, conflict_stream, conflict_duration.
// Every item gives exactly one result, in order.
// An enter item moves from the queue through the idle, write and done states.
// A check item visits up to eight streams in the next_stream state and, for each
// other active stream, searches up to sixteen ring slots. The search is paced by
// the single registered read port of the pair memories: each slot takes a read
// state and then an eval state.
// The back end works on one item at a time and starts the next item in the cycle
// its result is popped.
// A two-entry queue takes items while the back end works.
// After reset a clearing pass writes all-ones to all 256 pairs; items are queued
// but not executed until it ends. Config writes work throughout.
// When the receiver does not pop, the back end holds its result and takes no
// further item; the input queue fills and then raises full.
// Configuration is by APB at byte addresses 0,4,8,12,16.
module stream_duration_pair_checker_top import sdpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_cmd,
    input  logic [2:0]  i_stream_index,
    input  logic [1:0]  i_formatter,
    input  logic [31:0] i_seq_num,
    input  logic [31:0] i_duration,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [2:0]  o_conflict_stream,
    output logic [31:0] o_conflict_duration,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cfg    r_cfg;
    t_task   q_task;
    t_result res;
    logic    q_valid, q_take, res_valid, wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ring_length  <= 5'd16;
            r_cfg.stream_count <= 4'd8;
            r_cfg.active_mask  <= 8'hFF;
            r_cfg.dead_mask    <= 8'h00;
            r_cfg.tolerance    <= 31'd900;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                RegRingLength:  r_cfg.ring_length  <= pwdata[4:0];
                RegStreamCount: r_cfg.stream_count <= pwdata[3:0];
                RegActiveMask:  r_cfg.active_mask  <= pwdata[7:0];
                RegDeadMask:    r_cfg.dead_mask    <= pwdata[7:0];
                RegTolerance:   r_cfg.tolerance    <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            RegRingLength:  prdata = {27'd0, r_cfg.ring_length};
            RegStreamCount: prdata = {28'd0, r_cfg.stream_count};
            RegActiveMask:  prdata = {24'd0, r_cfg.active_mask};
            RegDeadMask:    prdata = {24'd0, r_cfg.dead_mask};
            RegTolerance:   prdata = {1'b0, r_cfg.tolerance};
            default:        prdata = '0;
        endcase
    end

    sdpc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_cmd(i_cmd), .i_stream_index(i_stream_index), .i_formatter(i_formatter),
        .i_seq_num(i_seq_num), .i_duration(i_duration),
        .o_task_valid(q_valid), .o_task(q_task), .i_task_take(q_take)
    );

    sdpc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_task_valid(q_valid), .i_task(q_task), .o_task_take(q_take),
        .o_res_valid(res_valid), .o_res(res), .i_res_take(pop && !empty)
    );

    assign empty               = !res_valid;
    assign o_status            = res.status;
    assign o_conflict_stream   = res.conflict_stream;
    assign o_conflict_duration = res.conflict_duration;
endmodule

>>> src/sdpc_checker.sv
`include "stream_duration_pair_checker_top_assert.svh"
module sdpc_checker import sdpc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_status,
    input logic [2:0]  o_conflict_stream,
    input logic [31:0] o_conflict_duration,
    input logic        pready
);
    `SDPC_ASSERT_IMPL(a_status_legal, i_clk, i_rst_n, !empty, o_status <= StatusUnknown)
    `SDPC_ASSERT_IMPL(a_ok_zero, i_clk, i_rst_n, !empty && o_status != StatusMismatch,
        o_conflict_stream == 3'd0 && o_conflict_duration == 32'd0)
    `SDPC_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, !empty && !pop,
        !empty && $stable(o_conflict_duration))
    `SDPC_ASSERT_IMPL(a_ready, i_clk, i_rst_n, 1'b1, pready)
endmodule

bind stream_duration_pair_checker_top sdpc_checker u_sdpc_checker (.*);
